// ----- rtl/core/ibmf_pkg.sv -----
// Shared types, codes and helpers for the IBM / IEEE float converter.
package ibmf_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP = 1'b1;

    localparam logic DIR_IBM_TO_IEEE = 1'b0;
    localparam logic DIR_IEEE_TO_IBM = 1'b1;

    localparam logic [30:0] IEEE_MAX_FINITE = 31'h7F7F_FFFF;

    typedef enum logic [1:0] {
        RNG_EXACT = 2'd0,
        RNG_UNDER = 2'd1,
        RNG_OVER  = 2'd2
    } t_rng_status;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_rng_status       status;
    } t_cvt_res;

    function automatic logic [WORD_W-1:0] rev_bytes(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ----- rtl/core/ibmf_ibm2ieee.sv -----
// Two-stage IBM hexadecimal float to IEEE-754 single datapath.
module ibmf_ibm2ieee (
    input  logic                   i_clk,
    input  logic [31:0]            i_word,
    output ibmf_pkg::t_cvt_res     o_res
);
    import ibmf_pkg::*;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] c;
        c = 5'd23;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                c = 5'(23 - i);
            end
        end
        return c;
    endfunction

    logic        r_sign;
    logic [6:0]  r_exp;
    logic [23:0] r_frac;
    logic        r_zero;
    logic [4:0]  r_lz;
    t_cvt_res    r_res;

    logic [23:0]       w_norm;
    logic signed [9:0] w_eb;
    t_cvt_res          n_res;

    always_ff @(posedge i_clk) begin
        r_sign <= i_word[31];
        r_exp  <= i_word[30:24];
        r_frac <= i_word[23:0];
        r_zero <= (i_word[30:24] == 7'd0) || (i_word[23:0] == 24'd0);
        r_lz   <= lzc24(i_word[23:0]);
    end

    always_comb begin
        w_norm = r_frac << r_lz;
        w_eb   = $signed({1'b0, r_exp, 2'b00}) - $signed({5'b0, r_lz}) - 10'sd130;
        if (r_zero) begin
            n_res.word   = '0;
            n_res.status = RNG_EXACT;
        end else if (w_eb <= 10'sd0) begin
            n_res.word   = '0;
            n_res.status = RNG_UNDER;
        end else if (w_eb >= 10'sd255) begin
            n_res.word   = {r_sign, IEEE_MAX_FINITE};
            n_res.status = RNG_OVER;
        end else begin
            n_res.word   = {r_sign, w_eb[7:0], w_norm[22:0]};
            n_res.status = RNG_EXACT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/ibmf_ieee2ibm.sv -----
// Two-stage IEEE-754 single to IBM hexadecimal float datapath.
module ibmf_ieee2ibm (
    input  logic        i_clk,
    input  logic [31:0] i_word,
    output logic [31:0] o_word
);
    import ibmf_pkg::*;

    logic        r_sign;
    logic [23:0] r_mant;
    logic [1:0]  r_shift;
    logic [6:0]  r_exp;
    logic        r_zero;
    logic [31:0] r_word;

    logic [1:0]  w_k;
    logic [8:0]  w_esum;
    logic [23:0] w_mant;

    always_comb begin
        w_k    = 2'd2 - i_word[24:23];
        w_esum = {1'b0, i_word[30:23]} + {7'b0, w_k} + 9'd130;
    end

    always_ff @(posedge i_clk) begin
        r_sign  <= i_word[31];
        r_mant  <= {1'b1, i_word[22:0]};
        r_shift <= w_k;
        r_exp   <= w_esum[8:2];
        r_zero  <= (i_word == 32'd0);
    end

    assign w_mant = r_mant >> r_shift;

    always_ff @(posedge i_clk) begin
        r_word <= r_zero ? 32'd0 : {r_sign, r_exp, w_mant};
    end

    assign o_word = r_word;

endmodule

// ----- rtl/core/ibm_ieee_float_converter.sv -----
// Top level of the IBM / IEEE-754 single precision float converter pipeline.
//
//  Channel   Handshake             Payload
//  input     start, busy           i_word_in, i_last_in
//  result    o_valid (strobe)      o_word_out, o_range_status, o_last_out
//  config    i_cfg_we              i_cfg_idx, i_cfg_data
//
// One word is taken every cycle; a result passes in order through the input register, the
// two datapath stages and the output register before it is on the ports.
// Synchronous active-low reset clears the valid pipeline and the configuration
// registers (direction IBM to IEEE, byte swap on). busy stays low: nothing stalls.
module ibm_ieee_float_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [31:0]                       i_word_in,
    input  logic                              i_last_in,
    output logic                              o_valid,
    output logic [31:0]                       o_word_out,
    output logic [1:0]                        o_range_status,
    output logic                              o_last_out,
    input  logic                              i_cfg_we,
    input  logic [ibmf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ibmf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ibmf_pkg::*;

    logic r_direction;
    logic r_byte_swap;

    logic        r_s0_valid, r_s1_valid, r_s2_valid;
    logic        r_s0_last, r_s1_last, r_s2_last;
    logic        r_s0_dir, r_s1_dir, r_s2_dir;
    logic        r_s0_swap, r_s1_swap, r_s2_swap;
    logic [31:0] r_s0_word;

    logic        r_out_valid;
    logic        r_out_dir;
    logic        r_out_last;
    logic [31:0] r_out_word;
    t_rng_status r_out_status;

    logic        w_accept;
    t_cvt_res    w_ibm_res;
    logic [31:0] w_ieee_word;
    logic [31:0] n_out_word;
    t_rng_status n_out_status;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_IBM_TO_IEEE;
            r_byte_swap <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                CFG_BYTE_SWAP: r_byte_swap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_valid  <= w_accept;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_last <= i_last_in;
        r_s0_dir  <= r_direction;
        r_s0_swap <= r_byte_swap;
        r_s0_word <= (r_direction == DIR_IBM_TO_IEEE && r_byte_swap) ?
                     rev_bytes(i_word_in) : i_word_in;
        r_s1_last <= r_s0_last;
        r_s1_dir  <= r_s0_dir;
        r_s1_swap <= r_s0_swap;
        r_s2_last <= r_s1_last;
        r_s2_dir  <= r_s1_dir;
        r_s2_swap <= r_s1_swap;
    end

    ibmf_ibm2ieee u_ibm2ieee (
        .i_clk  (i_clk),
        .i_word (r_s0_word),
        .o_res  (w_ibm_res)
    );

    ibmf_ieee2ibm u_ieee2ibm (
        .i_clk  (i_clk),
        .i_word (r_s0_word),
        .o_word (w_ieee_word)
    );

    always_comb begin
        if (r_s2_dir == DIR_IEEE_TO_IBM) begin
            n_out_word   = r_s2_swap ? rev_bytes(w_ieee_word) : w_ieee_word;
            n_out_status = RNG_EXACT;
        end else begin
            n_out_word   = w_ibm_res.word;
            n_out_status = w_ibm_res.status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_out_status <= n_out_status;
        r_out_last   <= r_s2_last;
        r_out_dir    <= r_s2_dir;
    end

    assign o_valid        = r_out_valid;
    assign o_word_out     = r_out_word;
    assign o_range_status = r_out_status;
    assign o_last_out     = r_out_last;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_valid)
        else $error("Accepted word did not produce a result after four stages.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> ##4 !o_valid)
        else $error("Result strobe without a matching transfer.");

    a_ibm_out_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_dir == DIR_IEEE_TO_IBM) |-> (o_range_status == RNG_EXACT))
        else $error("IEEE to IBM conversion flagged a range event.");

    a_over_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_status == RNG_OVER) |-> (o_word_out[30:0] == IEEE_MAX_FINITE))
        else $error("Overflow result is not the largest finite value.");

    a_under_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_status == RNG_UNDER) |-> (o_word_out == 32'd0))
        else $error("Underflow result is not zero.");

endmodule
